[hw/rtl/apc_ftd_pkg.sv]
`default_nettype none

package apc_ftd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_INTRO = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_TERM = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_G = 8'h47;
  localparam logic [BYTE_W-1:0] CH_ONE = 8'h31;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_EN = 2'd1;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/apc_ftd_if.sv]
`default_nettype none

interface apc_ftd_in_if
  import apc_ftd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface apc_ftd_out_if
  import apc_ftd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] data_byte;
  logic              last_of_run;

  modport source (output valid, output kind, output data_byte, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input last_of_run,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/apc_ftd_mem.sv]
`default_nettype none

module apc_ftd_mem
  import apc_ftd_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/apc_frame_text_demux_core.sv]
`default_nettype none

// Channel   Dir  Payload                          Accepted when
// in_ch     in   in_byte[7:0]                     valid && ready
// out_ch    out  kind, data_byte[7:0], last_of_run valid && ready
// cfg       in   cfg_idx[1:0], cfg_data[0]        cfg_we
//
// An escape pair stored in a frame makes two writes into the frame store, the escape
// byte and then, in ST_WR2, the held byte. A qualifying terminator then drains the
// frame, one byte per ST_RD/ST_LOAD pass, as the frame store read is registered.
// Reset is synchronous and clears the parser, counts and output valid flag. Input is
// accepted only in the idle state when the output register is empty or taken.
module apc_frame_text_demux_core
  import apc_ftd_pkg::*;
#(
  parameter int unsigned FRAME_STORE_BYTES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  apc_ftd_in_if.sink                 in_ch,
  apc_ftd_out_if.source              out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(FRAME_STORE_BYTES);
  localparam int unsigned CW = $clog2(FRAME_STORE_BYTES + 1);
  localparam logic [CW:0] FSB_W = (CW+1)'(FRAME_STORE_BYTES);

  typedef enum logic [2:0] {ST_IDLE, ST_TXT2, ST_WR2, ST_RD, ST_LOAD} state_t;
  typedef enum logic [1:0] {MD_TEXT, MD_TEXT_ESC, MD_FRAME, MD_FRAME_ESC} mode_t;

  state_t            st_r, st_nxt;
  mode_t             mode_r, mode_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic              g_ok_r, g_ok_nxt;
  logic              one_ok_r, one_ok_nxt;
  logic [BYTE_W-1:0] pend_r, pend_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]     drain_last_r, drain_last_nxt;
  logic              text_en_r, text_en_nxt;
  logic              frame_en_r, frame_en_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_rdata;

  logic              out_free;
  logic              in_ready;
  logic              in_acc;
  logic [BYTE_W-1:0] b;
  logic              full3;
  logic              full4;

  apc_ftd_mem #(
    .DEPTH (FRAME_STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_addr_r),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (st_r == ST_IDLE) && out_free;
  assign in_acc = in_ch.valid && in_ready;
  assign b = in_ch.in_byte;
  assign full3 = ({1'b0, held_r} + (CW+1)'(3)) >= FSB_W;
  assign full4 = ({1'b0, held_r} + (CW+1)'(4)) >= FSB_W;

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = out_kind_r;
  assign out_ch.data_byte = out_data_r;
  assign out_ch.last_of_run = out_last_r;

  always_comb begin
    st_nxt = st_r;
    mode_nxt = mode_r;
    held_nxt = held_r;
    g_ok_nxt = g_ok_r;
    one_ok_nxt = one_ok_r;
    pend_nxt = pend_r;
    rd_addr_nxt = rd_addr_r;
    drain_last_nxt = drain_last_r;
    text_en_nxt = text_en_r;
    frame_en_nxt = frame_en_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt = out_kind_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    mem_we = 1'b0;
    mem_waddr = held_r[AW-1:0];
    mem_wdata = b;
    mem_re = 1'b0;

    if (cfg_we && cfg_idx == CFG_TEXT_EN) begin
      text_en_nxt = cfg_data[0];
    end
    if (cfg_we && cfg_idx == CFG_FRAME_EN) begin
      frame_en_nxt = cfg_data[0];
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_r)
            MD_TEXT: begin
              if (b == CH_ESC) begin
                mode_nxt = MD_TEXT_ESC;
              end else if (text_en_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt = KIND_TEXT;
                out_data_nxt = b;
                out_last_nxt = 1'b1;
              end
            end
            MD_TEXT_ESC: begin
              if (b == CH_INTRO) begin
                mode_nxt = MD_FRAME;
                held_nxt = '0;
              end else begin
                if (text_en_r) begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt = KIND_TEXT;
                  out_data_nxt = CH_ESC;
                  out_last_nxt = (b == CH_ESC);
                end
                if (b != CH_ESC) begin
                  mode_nxt = MD_TEXT;
                  if (text_en_r) begin
                    pend_nxt = b;
                    st_nxt = ST_TXT2;
                  end
                end
              end
            end
            MD_FRAME: begin
              if (b == CH_ESC) begin
                mode_nxt = MD_FRAME_ESC;
              end else begin
                mem_we = 1'b1;
                held_nxt = held_r + CW'(1);
              end
              if (full3) begin
                mode_nxt = MD_TEXT;
                held_nxt = '0;
              end
            end
            default: begin
              if (b == CH_TERM) begin
                if (frame_en_r && held_r >= CW'(2) && g_ok_r && one_ok_r) begin
                  rd_addr_nxt = '0;
                  drain_last_nxt = held_r[AW-1:0] - AW'(1);
                  st_nxt = ST_RD;
                end
                mode_nxt = MD_TEXT;
                held_nxt = '0;
              end else begin
                mem_we = 1'b1;
                mem_wdata = CH_ESC;
                held_nxt = held_r + CW'(1);
                if (b == CH_ESC) begin
                  mode_nxt = MD_FRAME_ESC;
                end else begin
                  mode_nxt = MD_FRAME;
                  pend_nxt = b;
                  st_nxt = ST_WR2;
                end
                if (full4) begin
                  mode_nxt = MD_TEXT;
                  held_nxt = '0;
                  st_nxt = ST_IDLE;
                end
              end
            end
          endcase
        end
      end
      ST_TXT2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = KIND_TEXT;
          out_data_nxt = pend_r;
          out_last_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      ST_WR2: begin
        mem_we = 1'b1;
        mem_wdata = pend_r;
        held_nxt = held_r + CW'(1);
        st_nxt = ST_IDLE;
      end
      ST_RD: begin
        mem_re = 1'b1;
        st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = KIND_FRAME;
          out_data_nxt = mem_rdata;
          out_last_nxt = (rd_addr_r == drain_last_r);
          if (rd_addr_r == drain_last_r) begin
            st_nxt = ST_IDLE;
          end else begin
            rd_addr_nxt = rd_addr_r + AW'(1);
            st_nxt = ST_RD;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (mem_we && mem_waddr == AW'(0)) begin
      g_ok_nxt = (mem_wdata == CH_G);
    end
    if (mem_we && mem_waddr == AW'(1)) begin
      one_ok_nxt = (mem_wdata == CH_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      mode_r <= MD_TEXT;
      held_r <= '0;
      g_ok_r <= 1'b0;
      one_ok_r <= 1'b0;
      rd_addr_r <= '0;
      drain_last_r <= '0;
      text_en_r <= 1'b1;
      frame_en_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      g_ok_r <= g_ok_nxt;
      one_ok_r <= one_ok_nxt;
      rd_addr_r <= rd_addr_nxt;
      drain_last_r <= drain_last_nxt;
      text_en_r <= text_en_nxt;
      frame_en_r <= frame_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, held_r} < FSB_W))
    else $error("held count reached the store size");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RD || st_r == ST_LOAD) |-> (rd_addr_r <= drain_last_r))
    else $error("drain address ran past the frame end");

  a_no_stale_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !(out_valid_r && out_kind_r == KIND_FRAME))
    else $error("frame word present right after an accepted input word");
`endif

endmodule

`default_nettype wire
